@@ rtl/ngs_pkg.sv @@
// ngs_pkg: types, widths and constants for the normalized gradient step block
// used by normalized_gradient_step; no dependencies
package ngs_pkg;

  localparam int Q_W        = 16;
  localparam int SUM_W      = 37;
  localparam int SRC_W      = SUM_W + 1;
  localparam int ROOT_W     = 19;
  localparam int REM_W      = 22;
  localparam int PROD_W     = 2 * Q_W;
  localparam int BUF_DEPTH  = 64;
  localparam int ADDR_W     = $clog2(BUF_DEPTH);
  localparam int SQRT_STEPS = SRC_W / 2;
  localparam int DIV_STEPS  = Q_W;
  localparam int IT_W       = 5;

  localparam logic [Q_W-1:0] STEP_RESET = 16'd2048;
  localparam logic [Q_W-1:0] DELTA_MAX  = 16'h7fff;
  localparam logic [Q_W-1:0] DELTA_MIN  = 16'h8000;

  typedef struct packed {
    logic signed [Q_W-1:0] gradient;
    logic                  last;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] delta;
    logic                  last_res;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_ROOTI,
    ST_SQRT,
    ST_RD,
    ST_MUL,
    ST_OVF,
    ST_DIV
  } state_t;

  // magnitude of a two's complement word, -32768 maps to 32768
  function automatic logic [Q_W-1:0] abs_mag(input logic [Q_W-1:0] v);
    return v[Q_W-1] ? (~v + 16'd1) : v;
  endfunction

endpackage

@@ rtl/ngs_ram.sv @@
// ngs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ngs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/normalized_gradient_step.sv @@
// normalized_gradient_step: buffers a gradient vector, takes its norm and emits
// step_size * g / norm per element; uses ngs_pkg and ngs_ram
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  input   | start, busy, in_data           | item taken when start && !busy
//  result  | out_strobe, out_data           | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_data | write when valid && ready
//
// loading squares each element on the shared multiplier, then adds it to the sum
// on the closing element: a setup step, then the bit-pair square root
// then per result: buffer read, multiply, range check, 16 divide steps
// busy drops when the last result of the vector is presented, that result
// on the port in that same cycle
// reset is synchronous; the gradient buffer is not cleared, nothing else needed
// the receiver cannot stall, results leave on a fixed schedule
module normalized_gradient_step
  import ngs_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  in_item_t        in_data,
  output logic            out_strobe,
  output out_item_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [Q_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  state_t              state_r, state_nxt;
  logic [Q_W-1:0]      step_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic                last_r, last_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [SRC_W-1:0]    src_r, src_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [IT_W-1:0]     it_r, it_nxt;
  logic [Q_W-1:0]      num_r, num_nxt;
  logic [Q_W-1:0]      q_r, q_nxt;
  logic                ovf_r, ovf_nxt;
  logic                neg_r, neg_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // shared multiplier and shared subtract/compare unit
  logic [Q_W-1:0]      mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [REM_W-1:0]    sub_a, sub_b;
  logic [REM_W:0]      sub_d;
  logic                sub_ge;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [Q_W-1:0]      ram_rdata;
  logic                vec_done, emit_last;
  logic [Q_W-1:0]      delta_v;

  ngs_ram #(
    .WIDTH (Q_W),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.gradient),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mul_p  = mul_a * mul_b;
  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = ~sub_d[REM_W];

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_valid_r;
  assign out_data   = out_data_r;

  assign vec_done  = last_r || (cnt_r == CNT_W'(MAX_LEN));
  assign emit_last = (CNT_W'(k_r + 1'b1) == cnt_r);
  assign ram_waddr = ADDR_W'(cnt_r);
  assign ram_raddr = ADDR_W'(k_r);

  always_comb begin
    if (neg_r) begin
      delta_v = (ovf_r || q_r[Q_W-1]) ? DELTA_MIN : (~q_r + 16'd1);
    end else begin
      delta_v = (ovf_r || q_r[Q_W-1]) ? DELTA_MAX : q_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    prod_nxt      = prod_r;
    src_nxt       = src_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    it_nxt        = it_r;
    num_nxt       = num_r;
    q_nxt         = q_r;
    ovf_nxt       = ovf_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    mul_a         = abs_mag(in_data.gradient);
    mul_b         = abs_mag(in_data.gradient);
    sub_a         = {rem_r[REM_W-3:0], src_r[SRC_W-1 -: 2]};
    sub_b         = {1'b0, root_r, 2'b01};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ram_we    = 1'b1;
          prod_nxt  = mul_p;
          last_nxt  = in_data.last;
          cnt_nxt   = CNT_W'(cnt_r + 1'b1);
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        sum_nxt   = sum_r + {5'b0, prod_r};
        state_nxt = ST_IDLE;
        if (vec_done) begin
          state_nxt = ST_ROOTI;
        end
      end
      ST_ROOTI: begin
        // epsilon of one lsb keeps the norm at least one
        src_nxt   = {1'b0, sum_r} + 38'd1;
        sum_nxt   = '0;
        rem_nxt   = '0;
        root_nxt  = '0;
        it_nxt    = '0;
        k_nxt     = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        // one bit pair of the radicand per cycle
        rem_nxt   = sub_ge ? sub_d[REM_W-1:0] : sub_a;
        root_nxt  = {root_r[ROOT_W-2:0], sub_ge};
        src_nxt   = {src_r[SRC_W-3:0], 2'b00};
        it_nxt    = IT_W'(it_r + 1'b1);
        if (it_r == IT_W'(SQRT_STEPS - 1)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        mul_a     = abs_mag(ram_rdata);
        mul_b     = step_r;
        prod_nxt  = mul_p;
        neg_nxt   = ram_rdata[Q_W-1];
        state_nxt = ST_OVF;
      end
      ST_OVF: begin
        // quotient of 2^16 or more saturates either way
        sub_a     = {6'b0, prod_r[PROD_W-1:Q_W]};
        sub_b     = {3'b0, root_r};
        ovf_nxt   = sub_ge;
        rem_nxt   = sub_a;
        num_nxt   = prod_r[Q_W-1:0];
        q_nxt     = '0;
        it_nxt    = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        sub_a   = {1'b0, rem_r[REM_W-3:0], num_r[Q_W-1]};
        sub_b   = {3'b0, root_r};
        rem_nxt = sub_ge ? sub_d[REM_W-1:0] : sub_a;
        q_nxt   = {q_r[Q_W-2:0], sub_ge};
        num_nxt = {num_r[Q_W-2:0], 1'b0};
        it_nxt  = IT_W'(it_r + 1'b1);
        if (it_r == IT_W'(DIV_STEPS)) begin
          // quotient complete: present the result and move on
          rem_nxt       = rem_r;
          q_nxt         = q_r;
          num_nxt       = num_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{delta: delta_v, last_res: emit_last};
          if (emit_last) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = CNT_W'(k_r + 1'b1);
            state_nxt = ST_RD;
          end
        end else begin
          state_nxt = ST_DIV;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_data;
      end
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      it_r        <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    prod_r     <= prod_nxt;
    src_r      <= src_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    num_r      <= num_nxt;
    q_r        <= q_nxt;
    ovf_r      <= ovf_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  // results are spaced by a full element schedule
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result strobes");

  // the closing result leaves the block ready for a new vector
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last_res) |-> !busy)
    else $error("busy after final result");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_LEN))
    else $error("element count beyond vector length");

  // partial remainder stays below the divisor in a non-saturating divide
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && !ovf_r) |-> (rem_r < {3'b0, root_r}))
    else $error("divide remainder out of range");

  a_no_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (cnt_r != '0))
    else $error("emission with empty buffer");

endmodule

@@ test/normalized_gradient_step_tb.sv @@
`timescale 1ns / 100ps
// normalized_gradient_step_tb: self-checking bench for normalized_gradient_step
// predicts each update element from its own model of the norm and the divide
// depends on ngs_pkg and the normalized_gradient_step rtl
module normalized_gradient_step_tb
  import ngs_pkg::*;
();

  localparam int MAX_LEN      = 64;
  localparam int HALF_PERIOD  = 6;
  localparam int DRAIN_CYCLES = 40;
  localparam int END_CYCLES   = 64;
  localparam int LIMIT_CYCLES = 100000;
  localparam int NUM_PHASES   = 8;
  localparam int DIR_ROWS     = 26;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] value;
    logic        last;
    logic        typed;
    logic [15:0] typed_delta;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_strobe;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [Q_W-1:0] cfg_data;

  // predictor state
  logic signed [Q_W-1:0] grad_buf[$];
  logic [SUM_W-1:0]      sq_sum;
  logic [Q_W-1:0]        step_reg;
  out_item_t             delta_queue[$];
  int                    errors;

  // single-element vectors come out as +/- step_size, saturated to range, or zero for a zero gradient
  row_t plan [DIR_ROWS] = '{
    '{ROW_ITEM, 16'sd4096,  1'b1, 1'b1, 16'sd2048},
    '{ROW_ITEM, -16'sd4096, 1'b1, 1'b1, -16'sd2048},
    '{ROW_ITEM, 16'sd0,     1'b1, 1'b1, 16'sd0},
    '{ROW_ITEM, 16'h7fff,   1'b1, 1'b1, 16'sd2048},
    '{ROW_ITEM, 16'h8000,   1'b1, 1'b1, -16'sd2048},
    '{ROW_ITEM, 16'sd1,     1'b1, 1'b1, 16'sd2048},
    '{ROW_ITEM, -16'sd1,    1'b1, 1'b1, -16'sd2048},
    '{ROW_ITEM, 16'sd12288, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, -16'sd16384, 1'b1, 1'b0, 16'sd0},
    '{ROW_ITEM, 16'sd0,     1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, 16'sd0,     1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, 16'sd0,     1'b1, 1'b0, 16'sd0},
    '{ROW_ITEM, 16'sd8192,  1'b0, 1'b0, 16'sd0},
    // step change while a vector is half loaded
    '{ROW_CFG,  16'd4096,   1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, 16'sd8192,  1'b1, 1'b0, 16'sd0},
    '{ROW_CFG,  16'hffff,   1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, 16'sd4096,  1'b1, 1'b1, 16'h7fff},
    '{ROW_ITEM, -16'sd4096, 1'b1, 1'b1, 16'h8000},
    '{ROW_ITEM, -16'sd1,    1'b1, 1'b1, 16'h8000},
    '{ROW_ITEM, 16'h7fff,   1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, 16'sd1,     1'b1, 1'b0, 16'sd0},
    '{ROW_CFG,  16'd0,      1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, 16'h7fff,   1'b1, 1'b1, 16'sd0},
    '{ROW_ITEM, 16'h8000,   1'b1, 1'b1, 16'sd0},
    '{ROW_CFG,  16'd1,      1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, 16'h8000,   1'b1, 1'b1, -16'sd1}
  };

  normalized_gradient_step #(
    .MAX_LEN(MAX_LEN)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  function automatic longint unsigned magnitude(input logic signed [Q_W-1:0] v);
    return (v < 0) ? longint'(-int'(v)) : longint'(int'(v));
  endfunction

  // bit-by-bit floor square root, root fits in 19 bits
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  task automatic take_gradient(input in_item_t it, input bit typed_on,
                               input logic signed [Q_W-1:0] typed_delta);
    longint unsigned mag;
    longint unsigned norm;
    longint unsigned q;
    logic signed [Q_W-1:0] g;
    out_item_t r;
    grad_buf = {grad_buf, it.gradient};
    mag = magnitude(it.gradient);
    sq_sum = SUM_W'(longint'(sq_sum) + mag * mag);
    if (it.last || grad_buf.size() == MAX_LEN) begin
      norm = floor_root(longint'(sq_sum) + 1);
      foreach (grad_buf[k]) begin
        g = grad_buf[k];
        q = magnitude(g) * step_reg / norm;
        if (g < 0) begin
          r.delta = (q >= 64'd32768) ? DELTA_MIN : Q_W'(~q + 64'd1);
        end else begin
          r.delta = (q > 64'd32767) ? DELTA_MAX : Q_W'(q);
        end
        r.last_res = (k == grad_buf.size() - 1);
        if (typed_on) r.delta = typed_delta;
        delta_queue = {delta_queue, r};
      end
      grad_buf.delete();
      sq_sum = '0;
    end
  endtask

  // all driving tasks are entered and left at a falling edge
  task automatic send(input in_item_t it, input bit typed_on = 1'b0,
                      input logic signed [Q_W-1:0] typed_delta = '0);
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    take_gradient(it, typed_on, typed_delta);
    @(negedge clk);
  endtask

  task automatic gap(input int n);
    start <= 1'b0;
    in_data <= in_item_t'($urandom);
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_wait(input int extra);
    start <= 1'b0;
    while (delta_queue.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_step(input logic [Q_W-1:0] v);
    drain_wait(DRAIN_CYCLES);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    step_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [Q_W-1:0] pick_gradient();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'h7fff;
        1: return 16'h8000;
        2: return 16'h0000;
        3: return 16'h0001;
        default: return 16'hffff;
      endcase
    end else if (r <= 3) begin
      return Q_W'(int'($urandom_range(0, 255)) - 128);
    end
    return Q_W'($urandom);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 15);
    if (r < 9) return $urandom_range(1, 4);
    if (r < 14) return $urandom_range(5, 12);
    return $urandom_range(13, MAX_LEN);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (delta_queue.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected update: delta %0d last %0b", out_data.delta, out_data.last_res);
      end else begin
        want = delta_queue.pop_front();
        if (out_data.delta !== want.delta || out_data.last_res !== want.last_res) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("update mismatch: expected delta %0d last %0b, got delta %0d last %0b",
                     want.delta, want.last_res, out_data.delta, out_data.last_res);
        end
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("normalized_gradient_step_tb: done, errors");
    $finish;
  end

  initial begin
    in_item_t it;
    logic [Q_W-1:0] phase_step [NUM_PHASES];
    int left;
    int sent;
    int budget;
    bit no_close;
    bit want_full;
    bit idle_on;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    sq_sum = '0;
    step_reg = STEP_RESET;
    phase_step = '{16'd2048, 16'hffff, 16'd1, Q_W'($urandom), 16'd0, 16'h8000,
                   Q_W'($urandom_range(1024, 8192)), Q_W'($urandom)};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_step(plan[i].value);
      end else begin
        it.gradient = plan[i].value;
        it.last = plan[i].last;
        send(it, plan[i].typed, plan[i].typed_delta);
        if ($urandom_range(0, 2) == 0) gap($urandom_range(1, 9));
      end
    end

    left = 0;
    no_close = 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_step(phase_step[p]);
      idle_on = (p != NUM_PHASES - 1);
      // the first two phases each start one full-length vector
      want_full = (p < 2);
      budget = (p < 2) ? 72 : 14;
      sent = 0;
      while (sent < budget || (p == NUM_PHASES - 1 && left != 0)) begin
        if (left == 0) begin
          if (want_full) begin
            left = MAX_LEN;
            no_close = (p == 0);
            want_full = 1'b0;
          end else begin
            left = pick_length();
            no_close = 1'b0;
          end
        end
        it.gradient = pick_gradient();
        it.last = (left == 1) && !no_close;
        send(it);
        left--;
        sent++;
        if (p == 3 && sent == 12) drain_wait(1);
        if (idle_on && $urandom_range(0, 4) == 0) gap($urandom_range(1, 9));
      end
    end

    drain_wait(END_CYCLES);
    errors += delta_queue.size();
    if (errors == 0) begin
      $display("normalized_gradient_step_tb: done, clean");
    end else begin
      $display("normalized_gradient_step_tb: done, errors");
    end
    $finish;
  end

endmodule
